@@ hdl/ipfmt_pkg.sv @@
// ----------------------------------------------------------------------------
// IP address formatter package
// Shared character codes, group descriptor types and digit helpers for the
// address text formatter pipeline and its character serialiser.
// ----------------------------------------------------------------------------
package ipfmt_pkg;

  localparam int unsigned NumWords = 8;
  localparam int unsigned NumOctets = 4;

  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_LOWER_A = 7'h61;
  localparam logic [6:0] CH_COLON   = 7'h3a;
  localparam logic [6:0] CH_DOT     = 7'h2e;

  // Address words, word 0 leftmost (most significant).
  typedef logic [0:NumWords-1][15:0] ipfmt_words_t;

  // One printable group: up to four digits, right aligned, then separators.
  typedef struct packed {
    logic [15:0] digits;
    logic [2:0]  nd;
    logic [1:0]  nsep;
  } ipfmt_grp_t;

  // Everything the serialiser needs to print one address.
  typedef struct packed {
    ipfmt_grp_t [NumWords-1:0] grp;
    logic [NumWords-1:0]       live;
    logic                      dotted;
  } ipfmt_desc_t;

  // Lowercase hex character for one nibble; decimal digits map identically.
  function automatic logic [6:0] hex_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {3'b000, d};
    end else begin
      c = CH_LOWER_A + {3'b000, d} - 7'd10;
    end
    return c;
  endfunction

  // Split an octet into hundreds, tens and ones by compare chains.
  // Result is {hundreds[1:0], tens[3:0], ones[3:0]}.
  function automatic logic [9:0] dec_split(input logic [7:0] v);
    logic [1:0] h;
    logic [7:0] r;
    logic [3:0] t;
    logic [7:0] o;
    h = 2'd0;
    r = v;
    if (v >= 8'd200) begin
      h = 2'd2;
      r = v - 8'd200;
    end else if (v >= 8'd100) begin
      h = 2'd1;
      r = v - 8'd100;
    end
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r >= 8'(k * 10)) begin
        t = 4'(k);
      end
    end
    o = r - 8'({4'd0, t} * 8'd10);
    return {h, t, o[3:0]};
  endfunction

endpackage

@@ hdl/ipfmt_ser.sv @@
// ----------------------------------------------------------------------------
// IP address formatter character serialiser
// Walks the group descriptor of one address and puts out one character per
// cycle, skipping empty groups, and flags the final character.
// ----------------------------------------------------------------------------
module ipfmt_ser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  ipfmt_pkg::ipfmt_desc_t desc,
  output logic                   free,
  output logic                   out_valid,
  output logic [6:0]             out_char,
  output logic                   out_last
);
  import ipfmt_pkg::*;

  logic        act_r, act_nxt;
  logic [2:0]  g_r, g_nxt;
  logic [2:0]  p_r, p_nxt;
  ipfmt_desc_t desc_r;

  ipfmt_grp_t  grp;
  logic [2:0]  len;
  logic        end_grp;
  logic [2:0]  nxt_g;
  logic        found;
  logic [2:0]  idx;
  logic [15:0] sh;

  // Current group, its length and the next group that prints anything.
  always_comb begin
    grp     = desc_r.grp[g_r];
    len     = grp.nd + {1'b0, grp.nsep};
    end_grp = (p_r == len - 3'd1);
    nxt_g   = g_r;
    found   = 1'b0;
    for (int i = NumWords - 1; i >= 0; i--) begin
      if (desc_r.live[i] && (3'(i) > g_r)) begin
        nxt_g = 3'(i);
        found = 1'b1;
      end
    end
  end

  // Character select: a digit while inside the digit part, else a separator.
  always_comb begin
    idx = grp.nd - 3'd1 - p_r;
    sh  = grp.digits >> {idx[1:0], 2'b00};
    if (p_r < grp.nd) begin
      out_char = hex_char(sh[3:0]);
    end else if (desc_r.dotted) begin
      out_char = CH_DOT;
    end else begin
      out_char = CH_COLON;
    end
  end

  assign out_valid = act_r;
  assign out_last  = act_r && end_grp && !found;
  assign free      = !act_r || (end_grp && !found);

  // Position update; a new descriptor is taken as the last character goes.
  always_comb begin
    act_nxt = act_r;
    g_nxt   = g_r;
    p_nxt   = p_r;
    if (load) begin
      act_nxt = 1'b1;
      g_nxt   = 3'd0;
      p_nxt   = 3'd0;
    end else if (act_r) begin
      if (end_grp) begin
        if (found) begin
          g_nxt = nxt_g;
          p_nxt = 3'd0;
        end else begin
          act_nxt = 1'b0;
        end
      end else begin
        p_nxt = p_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
    g_r <= g_nxt;
    p_r <= p_nxt;
    if (load) begin
      desc_r <= desc;
    end
  end

endmodule

@@ hdl/ip_address_text_formatter.sv @@
// ----------------------------------------------------------------------------
// IP address text formatter
// An accepted address moves through stages 1, 2 and 3 into the serialiser.
// Throughput: one character per cycle while an address is printed; its text is 2
// to 39 characters long, with no gap between addresses that are queued.
// Three pipeline stages buffer further addresses; the receiver cannot stall.
// Reset clears all valid bits and the serialiser; payload is not reset.
// ----------------------------------------------------------------------------
module ip_address_text_formatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_addr_high,
  input  logic [63:0] in_addr_low,
  output logic        out_valid,
  output logic [6:0]  out_char,
  output logic        out_last_char
);
  import ipfmt_pkg::*;

  // Pipeline control.
  logic s1_v_r, s1_v_nxt;
  logic s2_v_r, s2_v_nxt;
  logic s3_v_r, s3_v_nxt;
  logic take, adv2, adv3, ld, ser_free;

  // Stage 1: words, zero flags, hex digit counts, mapped check.
  ipfmt_words_t          w_in;
  ipfmt_words_t          w1_r;
  logic [NumWords-1:0]   z_in, z1_r;
  logic [0:NumWords-1][2:0] hnd_in, hnd1_r, hnd2_r;
  logic                  map_in, map1_r, map2_r;

  // Stage 2: zero run and octet digits.
  ipfmt_words_t          w2_r;
  logic [2:0]            rs_c, rs2_r;
  logic [3:0]            rl_c, rl2_r;
  logic [0:NumOctets-1][9:0] dec_c, dec2_r;

  // Stage 3: group descriptor.
  ipfmt_desc_t           desc_c, desc3_r;

  assign take = start && !busy;
  assign ld   = s3_v_r && ser_free;
  assign adv3 = s2_v_r && (!s3_v_r || ld);
  assign adv2 = s1_v_r && (!s2_v_r || adv3);
  assign busy = s1_v_r && !adv2;

  // Valid bits move with the data; a stage holds while its successor is full and cannot pass its data on.
  always_comb begin
    s1_v_nxt = take ? 1'b1 : (adv2 ? 1'b0 : s1_v_r);
    s2_v_nxt = adv2 ? 1'b1 : (adv3 ? 1'b0 : s2_v_r);
    s3_v_nxt = adv3 ? 1'b1 : (ld ? 1'b0 : s3_v_r);
  end

  // Word split, zero flags and hex digit counts of the incoming address.
  always_comb begin
    w_in = {in_addr_high, in_addr_low};
    for (int i = 0; i < NumWords; i++) begin
      z_in[i] = (w_in[i] == 16'h0000);
      if (w_in[i][15:12] != 4'h0) begin
        hnd_in[i] = 3'd4;
      end else if (w_in[i][11:8] != 4'h0) begin
        hnd_in[i] = 3'd3;
      end else if (w_in[i][7:4] != 4'h0) begin
        hnd_in[i] = 3'd2;
      end else begin
        hnd_in[i] = 3'd1;
      end
    end
    map_in = z_in[0] && z_in[1] && z_in[2] && z_in[3] && z_in[4] &&
             (w_in[5] == 16'hffff);
  end

  // Longest zero run, scanned from the right so that the rightmost one wins.
  always_comb begin
    logic [3:0] cur;
    cur  = 4'd0;
    rl_c = 4'd0;
    rs_c = 3'd0;
    for (int i = NumWords - 1; i >= 0; i--) begin
      if (z1_r[i]) begin
        cur = cur + 4'd1;
        if (cur > rl_c) begin
          rl_c = cur;
          rs_c = 3'(i);
        end
      end else begin
        cur = 4'd0;
      end
    end
    dec_c[0] = dec_split(w1_r[6][15:8]);
    dec_c[1] = dec_split(w1_r[6][7:0]);
    dec_c[2] = dec_split(w1_r[7][15:8]);
    dec_c[3] = dec_split(w1_r[7][7:0]);
  end

  // Group descriptors: dotted octets, or hex words with the run as "::".
  always_comb begin
    logic [3:0] idx;
    logic       in_run;
    logic [3:0] run_end;
    run_end = {1'b0, rs2_r} + rl2_r;
    desc_c.dotted = map2_r;
    for (int i = 0; i < NumWords; i++) begin
      idx    = 4'(i);
      in_run = (rl2_r != 4'd0) && (idx >= {1'b0, rs2_r}) && (idx < run_end);
      desc_c.grp[i].digits = w2_r[i];
      desc_c.grp[i].nd     = 3'd0;
      desc_c.grp[i].nsep   = 2'd0;
      if (map2_r) begin
        if (i < NumOctets) begin
          desc_c.grp[i].digits = {6'd0, dec2_r[i]};
          if (dec2_r[i][9:8] != 2'd0) begin
            desc_c.grp[i].nd = 3'd3;
          end else if (dec2_r[i][7:4] != 4'd0) begin
            desc_c.grp[i].nd = 3'd2;
          end else begin
            desc_c.grp[i].nd = 3'd1;
          end
          desc_c.grp[i].nsep = (i == NumOctets - 1) ? 2'd0 : 2'd1;
        end
      end else if (in_run) begin
        if (idx == {1'b0, rs2_r}) begin
          desc_c.grp[i].nsep = (i == 0) ? 2'd2 : 2'd1;
        end
      end else begin
        desc_c.grp[i].nd   = hnd2_r[i];
        desc_c.grp[i].nsep = (i == NumWords - 1) ? 2'd0 : 2'd1;
      end
      desc_c.live[i] = (desc_c.grp[i].nd != 3'd0) || (desc_c.grp[i].nsep != 2'd0);
    end
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
    end
    if (take) begin
      w1_r   <= w_in;
      z1_r   <= z_in;
      hnd1_r <= hnd_in;
      map1_r <= map_in;
    end
    if (adv2) begin
      w2_r   <= w1_r;
      hnd2_r <= hnd1_r;
      map2_r <= map1_r;
      rs2_r  <= rs_c;
      rl2_r  <= rl_c;
      dec2_r <= dec_c;
    end
    if (adv3) begin
      desc3_r <= desc_c;
    end
  end

  // Character serialiser; takes the next descriptor as the last character goes.
  ipfmt_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ld),
    .desc      (desc3_r),
    .free      (ser_free),
    .out_valid (out_valid),
    .out_char  (out_char),
    .out_last  (out_last_char)
  );

endmodule
